[src/vnsc_pkg.sv]
// Package for the nearest-seed colourer: sizes, lane type and the lane compare.
package vnsc_pkg;

  localparam int MAX_SEEDS  = 16;
  localparam int COORD_BITS = 10;
  localparam int COLOR_BITS = 16;
  localparam int RANK_OUT_W = 4;

  localparam int SLOT_W = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int CNT_W  = $clog2(MAX_SEEDS + 1);
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIST_W = SQ_W + 1;
  localparam int LEVELS = $clog2(MAX_SEEDS);
  localparam int LEAVES = 1 << LEVELS;
  // diff, square, sum, tree levels, output register
  localparam int LATENCY = LEVELS + 4;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                  valid;
    logic [DIST_W-1:0]     sq_dist;
    logic [SLOT_W-1:0]     rank;
    logic [COLOR_BITS-1:0] color;
  } lane_t;

  // Nearer of two candidates; on equal distance the older (lower rank) wins
  function automatic lane_t pick(input lane_t a, input lane_t b);
    logic a_wins;
    a_wins = a.valid && (!b.valid || (a.sq_dist < b.sq_dist) ||
                         ((a.sq_dist == b.sq_dist) && (a.rank < b.rank)));
    return a_wins ? a : b;
  endfunction

endpackage

[src/voronoi_nearest_seed_colorer.sv]
// Top level: seed table in flip-flops and the pipelined nearest-seed search.
//
// Usage
//   One command channel: an item is taken at a rising edge with start high and
//   busy low. command = add puts a seed (x_coord, y_coord, seed_color) into the
//   table; once the table holds MAX_SEEDS seeds the oldest one is replaced.
//   command = query searches all held seeds for the one nearest to
//   (x_coord, y_coord) by squared distance, the older seed winning a tie.
//   Throughput: one item per clock. busy is high only during reset.
//   An add causes no result and takes effect for the very next item.
//   A query gives one result, marked by done for one cycle, taken at the edge
//   ending that cycle. Its path: diff, square, sum, one registered compare
//   level per halving of the seed count, output register.
//   Results leave in query order; the receiver cannot stall the pipeline.
//   With no seed held, the result has seed_found 0, pixel_color 0, seed_rank 0.
//   Reset (rst, synchronous) empties the table and drops items in flight;
//   table contents are not cleared, only the seed count and oldest pointer.
module voronoi_nearest_seed_colorer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            command,
  input  logic [vnsc_pkg::COORD_BITS-1:0] x_coord,
  input  logic [vnsc_pkg::COORD_BITS-1:0] y_coord,
  input  logic [vnsc_pkg::COLOR_BITS-1:0] seed_color,
  output logic                            done,
  output logic [vnsc_pkg::COLOR_BITS-1:0] pixel_color,
  output logic                            seed_found,
  output logic [vnsc_pkg::RANK_OUT_W-1:0] seed_rank
);

  localparam int N  = vnsc_pkg::MAX_SEEDS;
  localparam int CW = vnsc_pkg::COORD_BITS;

  // seed table, one lane per slot
  logic [CW-1:0]                   tab_x     [N];
  logic [CW-1:0]                   tab_y     [N];
  logic [vnsc_pkg::COLOR_BITS-1:0] tab_color [N];
  logic [vnsc_pkg::CNT_W-1:0]      seed_count;
  logic [vnsc_pkg::SLOT_W-1:0]     oldest_slot;

  logic accept, add_item, query_item;
  logic [vnsc_pkg::SLOT_W:0]   wr_sum;
  logic [vnsc_pkg::SLOT_W-1:0] wr_slot;
  logic [vnsc_pkg::SLOT_W-1:0] oldest_next;

  assign busy       = rst;
  assign accept     = start && !busy;
  assign add_item   = accept && (command == vnsc_pkg::CMD_ADD);
  assign query_item = accept && (command == vnsc_pkg::CMD_QUERY);

  // write slot: next free rank while filling, else the oldest slot
  always_comb begin
    wr_sum = (vnsc_pkg::SLOT_W+1)'(oldest_slot) + (vnsc_pkg::SLOT_W+1)'(seed_count);
    if (wr_sum >= (vnsc_pkg::SLOT_W+1)'(N)) begin
      wr_sum = wr_sum - (vnsc_pkg::SLOT_W+1)'(N);
    end
    if (seed_count < vnsc_pkg::CNT_W'(N)) begin
      wr_slot = wr_sum[vnsc_pkg::SLOT_W-1:0];
    end else begin
      wr_slot = oldest_slot;
    end
    if (oldest_slot == vnsc_pkg::SLOT_W'(N - 1)) begin
      oldest_next = '0;
    end else begin
      oldest_next = oldest_slot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_count  <= '0;
      oldest_slot <= '0;
    end else if (add_item) begin
      if (seed_count < vnsc_pkg::CNT_W'(N)) begin
        seed_count <= seed_count + 1'b1;
      end else begin
        oldest_slot <= oldest_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (add_item) begin
      tab_x[wr_slot]     <= x_coord;
      tab_y[wr_slot]     <= y_coord;
      tab_color[wr_slot] <= seed_color;
    end
  end

  // stage 1: per-lane absolute differences, rank and liveness
  logic                            s1_vld;
  logic [CW-1:0]                   s1_dx    [N];
  logic [CW-1:0]                   s1_dy    [N];
  logic                            s1_live  [N];
  logic [vnsc_pkg::SLOT_W-1:0]     s1_rank  [N];
  logic [vnsc_pkg::COLOR_BITS-1:0] s1_color [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= query_item;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_lane
    logic [vnsc_pkg::SLOT_W:0] rank_w;
    always_comb begin
      if (vnsc_pkg::SLOT_W'(i) >= oldest_slot) begin
        rank_w = (vnsc_pkg::SLOT_W+1)'(i) - (vnsc_pkg::SLOT_W+1)'(oldest_slot);
      end else begin
        rank_w = (vnsc_pkg::SLOT_W+1)'(i + N) - (vnsc_pkg::SLOT_W+1)'(oldest_slot);
      end
    end

    always_ff @(posedge clk) begin
      s1_dx[i]    <= (x_coord >= tab_x[i]) ? x_coord - tab_x[i] : tab_x[i] - x_coord;
      s1_dy[i]    <= (y_coord >= tab_y[i]) ? y_coord - tab_y[i] : tab_y[i] - y_coord;
      s1_live[i]  <= (vnsc_pkg::CNT_W'(rank_w) < seed_count);
      s1_rank[i]  <= rank_w[vnsc_pkg::SLOT_W-1:0];
      s1_color[i] <= tab_color[i];
    end
  end

  // stage 2: squares
  logic                            s2_vld;
  logic [vnsc_pkg::SQ_W-1:0]       s2_sqx   [N];
  logic [vnsc_pkg::SQ_W-1:0]       s2_sqy   [N];
  logic                            s2_live  [N];
  logic [vnsc_pkg::SLOT_W-1:0]     s2_rank  [N];
  logic [vnsc_pkg::COLOR_BITS-1:0] s2_color [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_sq
    always_ff @(posedge clk) begin
      s2_sqx[i]   <= vnsc_pkg::SQ_W'(s1_dx[i]) * vnsc_pkg::SQ_W'(s1_dx[i]);
      s2_sqy[i]   <= vnsc_pkg::SQ_W'(s1_dy[i]) * vnsc_pkg::SQ_W'(s1_dy[i]);
      s2_live[i]  <= s1_live[i];
      s2_rank[i]  <= s1_rank[i];
      s2_color[i] <= s1_color[i];
    end
  end

  // stage 3: distance sum, forming the leaves of the compare tree
  vnsc_pkg::lane_t tree [vnsc_pkg::LEVELS+1][vnsc_pkg::LEAVES];
  logic            tvld [vnsc_pkg::LEVELS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      tvld[0] <= 1'b0;
    end else begin
      tvld[0] <= s2_vld;
    end
  end

  for (genvar i = 0; i < vnsc_pkg::LEAVES; i++) begin : g_leaf
    if (i < N) begin : g_real
      always_ff @(posedge clk) begin
        tree[0][i].valid   <= s2_live[i];
        tree[0][i].sq_dist <= vnsc_pkg::DIST_W'(s2_sqx[i]) + vnsc_pkg::DIST_W'(s2_sqy[i]);
        tree[0][i].rank    <= s2_rank[i];
        tree[0][i].color   <= s2_color[i];
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        tree[0][i] <= '0;
      end
    end
  end

  // registered minimum tree, one compare level per stage
  for (genvar l = 1; l <= vnsc_pkg::LEVELS; l++) begin : g_lvl
    always_ff @(posedge clk) begin
      if (rst) begin
        tvld[l] <= 1'b0;
      end else begin
        tvld[l] <= tvld[l-1];
      end
    end
    for (genvar j = 0; j < (vnsc_pkg::LEAVES >> l); j++) begin : g_node
      always_ff @(posedge clk) begin
        tree[l][j] <= vnsc_pkg::pick(tree[l-1][2*j], tree[l-1][2*j+1]);
      end
    end
    for (genvar j = (vnsc_pkg::LEAVES >> l); j < vnsc_pkg::LEAVES; j++) begin : g_unused
      always_ff @(posedge clk) begin
        tree[l][j] <= '0;
      end
    end
  end

  // output register; fields zero when no seed is held
  vnsc_pkg::lane_t best;
  assign best = tree[vnsc_pkg::LEVELS][0];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tvld[vnsc_pkg::LEVELS];
    end
  end

  always_ff @(posedge clk) begin
    seed_found  <= best.valid;
    pixel_color <= best.valid ? best.color : '0;
    seed_rank   <= best.valid ? vnsc_pkg::RANK_OUT_W'(best.rank) : '0;
  end

  // checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && (command == vnsc_pkg::CMD_QUERY),
                   vnsc_pkg::LATENCY))
    else $error("result without a matching query");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    seed_count <= vnsc_pkg::CNT_W'(N))
    else $error("seed count beyond table size");

  a_oldest_full: assert property (@(posedge clk) disable iff (rst)
    (oldest_slot != '0) |-> (seed_count == vnsc_pkg::CNT_W'(N)))
    else $error("oldest pointer moved before table filled");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !seed_found) |-> ((pixel_color == '0) && (seed_rank == '0)))
    else $error("empty result carries nonzero fields");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (add_item && (seed_count < vnsc_pkg::CNT_W'(N))) |=>
      (seed_count == $past(seed_count) + 1'b1))
    else $error("add did not grow seed count");

endmodule
